// ===== sv/cab_pkg.sv =====
// Shared definitions for the coverage alpha blend unit.
// Holds field widths, register indexes, channel layout tables and the divide-by-255 helper.
// No dependencies; every other file of the unit imports this package.
package cab_pkg;

  localparam int PIX_W  = 32;
  localparam int CH_W   = 8;
  localparam int NUM_W  = 17;
  localparam int CFG_IDX_W = 1;

  localparam int DIV_STAGES = 3;
  localparam int DIV_STEPS  = (NUM_W + DIV_STAGES - 1) / DIV_STAGES;
  localparam int DIV_W      = DIV_STAGES * DIV_STEPS;

  localparam logic [24:0] DIV255_MUL = 25'h1010102;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t REG_FILL_COLOR   = 1'b0;
  localparam cfg_idx_t REG_PIXEL_LAYOUT = 1'b1;

  typedef logic [1:0] byte_pos_t;
  localparam byte_pos_t LAY_R [4] = '{2'd0, 2'd2, 2'd1, 2'd3};
  localparam byte_pos_t LAY_G [4] = '{2'd1, 2'd1, 2'd2, 2'd2};
  localparam byte_pos_t LAY_B [4] = '{2'd2, 2'd0, 2'd3, 2'd1};
  localparam byte_pos_t LAY_A [4] = '{2'd3, 2'd3, 2'd0, 2'd0};

  localparam logic [CH_W-1:0] CH_MAX = 8'hff;

  // Truncating division by 255 for values below 255 * 2^16, by reciprocal multiplication.
  function automatic logic [15:0] div255(input logic [23:0] x);
    logic [48:0] p;
    p = 49'(x) * 49'(DIV255_MUL);
    return p[47:32];
  endfunction

endpackage

// ===== sv/cab_div.sv =====
// Pipelined restoring divider for one colour channel of the blend unit.
// Several quotient bits are resolved per register stage.
// Depends on cab_pkg for widths and stage counts.
module cab_div
  import cab_pkg::*;
(
  input  logic             clk,
  input  logic [NUM_W-1:0] num,
  input  logic [CH_W-1:0]  den,
  output logic [DIV_W-1:0] quo
);

  logic [DIV_W-1:0] num_q [DIV_STAGES+1];
  logic [DIV_W-1:0] quo_q [DIV_STAGES+1];
  logic [CH_W-1:0]  rem_q [DIV_STAGES+1];
  logic [CH_W-1:0]  den_q [DIV_STAGES+1];

  assign num_q[0] = DIV_W'(num);
  assign quo_q[0] = '0;
  assign rem_q[0] = '0;
  assign den_q[0] = den;

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    logic [DIV_W-1:0] num_c;
    logic [DIV_W-1:0] quo_c;
    logic [CH_W-1:0]  rem_c;

    always_comb begin
      logic [CH_W:0] t;
      num_c = num_q[s];
      quo_c = quo_q[s];
      rem_c = rem_q[s];
      for (int k = 0; k < DIV_STEPS; k++) begin
        t     = {rem_c, num_c[DIV_W-1]};
        num_c = {num_c[DIV_W-2:0], 1'b0};
        if (t >= {1'b0, den_q[s]}) begin
          rem_c = CH_W'(t - {1'b0, den_q[s]});
          quo_c = {quo_c[DIV_W-2:0], 1'b1};
        end else begin
          rem_c = t[CH_W-1:0];
          quo_c = {quo_c[DIV_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      num_q[s+1] <= num_c;
      quo_q[s+1] <= quo_c;
      rem_q[s+1] <= rem_c;
      den_q[s+1] <= den_q[s];
    end
  end

  assign quo = quo_q[DIV_STAGES];

endmodule

// ===== sv/coverage_alpha_blend.sv =====
// Top level of the coverage alpha blend unit: config registers, blend pipeline, output stage.
// Depends on cab_pkg and instantiates three cab_div channel dividers.
//
//   channel   handshake               payload
//   input     start / busy            dest_pixel, coverage
//   result    done (strobe)           new_pixel, changed
//   config    cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One beat is accepted every cycle while busy is low; each result leaves the output register marked by done.
// The depth is set by the alpha multiplies, the divisions by 255 and the three-stage divider.
// Synchronous reset clears the config registers, the valid bits and done; busy is high only during reset.
// The receiver takes every result, so the pipeline never halts.
module coverage_alpha_blend
  import cab_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  logic [PIX_W-1:0] dest_pixel,
  input  logic [CH_W-1:0]  coverage,
  output logic             done,
  output logic [PIX_W-1:0] new_pixel,
  output logic             changed,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  cfg_idx_t         cfg_index,
  input  logic [PIX_W-1:0] cfg_data
);

  logic [PIX_W-1:0] fill_color;
  logic [1:0]       pixel_layout;

  logic [CH_W-1:0] fr, fg, fb;
  byte_pos_t       pr, pg, pb, pa;

  assign busy      = rst;
  assign cfg_ready = 1'b1;

  assign fr = fill_color[31:24];
  assign fg = fill_color[23:16];
  assign fb = fill_color[15:8];
  assign pr = LAY_R[pixel_layout];
  assign pg = LAY_G[pixel_layout];
  assign pb = LAY_B[pixel_layout];
  assign pa = LAY_A[pixel_layout];

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_color   <= '0;
      pixel_layout <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_FILL_COLOR:   fill_color   <= cfg_data;
        REG_PIXEL_LAYOUT: pixel_layout <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  logic             v1, v2, v3, v4, v5;
  logic [PIX_W-1:0] px1, px2, px3, px4, px5;
  logic [15:0]      prod1;
  logic [CH_W-1:0]  sa2, sa3, sa4, sa5;
  logic [15:0]      m13;
  logic [15:0]      cdda3 [3];
  logic [15:0]      cssa3 [3];
  logic [15:0]      cssa4 [3];
  logic [23:0]      t4    [3];
  logic [CH_W-1:0]  oa4, oa5;
  logic [NUM_W-1:0] n5    [3];

  logic [CH_W-1:0] da2;
  logic [CH_W-1:0] cd2 [3];
  logic [CH_W-1:0] cs2 [3];
  logic [CH_W-1:0] inv2, inv3;

  assign da2    = px2[{pa, 3'b000} +: CH_W];
  assign cd2[0] = px2[{pr, 3'b000} +: CH_W];
  assign cd2[1] = px2[{pg, 3'b000} +: CH_W];
  assign cd2[2] = px2[{pb, 3'b000} +: CH_W];
  assign cs2[0] = fr;
  assign cs2[1] = fg;
  assign cs2[2] = fb;
  assign inv2   = CH_MAX - sa2;
  assign inv3   = CH_MAX - sa3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      v1 <= start && !busy;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    px1   <= dest_pixel;
    prod1 <= 16'(fill_color[7:0]) * 16'(coverage);

    px2 <= px1;
    sa2 <= CH_W'(div255(24'(prod1)));

    px3 <= px2;
    sa3 <= sa2;
    m13 <= 16'(da2) * 16'(inv2);
    for (int c = 0; c < 3; c++) begin
      cdda3[c] <= 16'(cd2[c]) * 16'(da2);
      cssa3[c] <= 16'(cs2[c]) * 16'(sa2);
    end

    px4 <= px3;
    sa4 <= sa3;
    oa4 <= sa3 + CH_W'(div255(24'(m13)));
    for (int c = 0; c < 3; c++) begin
      cssa4[c] <= cssa3[c];
      t4[c]    <= 24'(cdda3[c]) * 24'(inv3);
    end

    px5 <= px4;
    sa5 <= sa4;
    oa5 <= oa4;
    for (int c = 0; c < 3; c++) begin
      n5[c] <= NUM_W'(cssa4[c]) + NUM_W'(div255(t4[c]));
    end
  end

  logic [DIV_W-1:0] quo [3];

  for (genvar c = 0; c < 3; c++) begin : g_chan
    cab_div u_div (
      .clk (clk),
      .num (n5[c]),
      .den (oa5),
      .quo (quo[c])
    );
  end

  logic             vd  [DIV_STAGES];
  logic [PIX_W-1:0] pxd [DIV_STAGES];
  logic [CH_W-1:0]  sad [DIV_STAGES];
  logic [CH_W-1:0]  oad [DIV_STAGES];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < DIV_STAGES; s++) begin
        vd[s] <= 1'b0;
      end
    end else begin
      vd[0] <= v5;
      for (int s = 1; s < DIV_STAGES; s++) begin
        vd[s] <= vd[s-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    pxd[0] <= px5;
    sad[0] <= sa5;
    oad[0] <= oa5;
    for (int s = 1; s < DIV_STAGES; s++) begin
      pxd[s] <= pxd[s-1];
      sad[s] <= sad[s-1];
      oad[s] <= oad[s-1];
    end
  end

  logic [PIX_W-1:0] pix_next;
  logic             changed_next;
  logic [PIX_W-1:0] px_f;
  logic [CH_W-1:0]  sa_f, oa_f;

  assign px_f = pxd[DIV_STAGES-1];
  assign sa_f = sad[DIV_STAGES-1];
  assign oa_f = oad[DIV_STAGES-1];

  always_comb begin
    pix_next     = '0;
    changed_next = 1'b1;
    priority if (sa_f == '0) begin
      pix_next     = px_f;
      changed_next = 1'b0;
    end else if (sa_f == CH_MAX) begin
      pix_next[{pr, 3'b000} +: CH_W] = fr;
      pix_next[{pg, 3'b000} +: CH_W] = fg;
      pix_next[{pb, 3'b000} +: CH_W] = fb;
      pix_next[{pa, 3'b000} +: CH_W] = CH_MAX;
    end else if (oa_f == '0) begin
      pix_next = '0;
    end else begin
      pix_next[{pr, 3'b000} +: CH_W] = quo[0][CH_W-1:0];
      pix_next[{pg, 3'b000} +: CH_W] = quo[1][CH_W-1:0];
      pix_next[{pb, 3'b000} +: CH_W] = quo[2][CH_W-1:0];
      pix_next[{pa, 3'b000} +: CH_W] = oa_f;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vd[DIV_STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    new_pixel <= pix_next;
    changed   <= changed_next;
  end

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for coverage_alpha_blend: a directed table, then random pixel traffic.
// Expected pixels come from the table or a predictor in this file; cab_pkg supplies port types.
// Needs only the unit's RTL and cab_pkg.
module tb
  import cab_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic {ROW_CFG, ROW_PIX} row_kind_e;
  typedef enum int {CH_RED, CH_GREEN, CH_BLUE, CH_ALPHA} chan_e;
  typedef enum logic [1:0] {LAYOUT_RGBA, LAYOUT_BGRA, LAYOUT_ARGB, LAYOUT_ABGR} layout_e;

  localparam logic [31:0] ALPHA_FULL = 32'd255;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             written;
  } blend_res_t;

  typedef struct packed {
    row_kind_e        kind;
    cfg_idx_t         idx;
    logic [PIX_W-1:0] data;
    logic [CH_W-1:0]  cov;
    logic             typed;
    logic [PIX_W-1:0] want_pixel;
    logic             want_written;
  } dir_row_t;

  localparam int NUM_ROWS = 29;
  localparam dir_row_t DIR_ROWS [NUM_ROWS] = '{
    '{ROW_PIX, REG_FILL_COLOR,   32'hDEADBEEF, 8'd255, 1'b1, 32'hDEADBEEF, 1'b0},
    '{ROW_PIX, REG_FILL_COLOR,   32'hFFFFFFFF, 8'd0,   1'b1, 32'hFFFFFFFF, 1'b0},
    '{ROW_CFG, REG_FILL_COLOR,   32'h112233FF, 8'd0,   1'b0, 32'h0,        1'b0},
    '{ROW_PIX, REG_FILL_COLOR,   32'hA5A5A5A5, 8'd255, 1'b1, 32'hFF332211, 1'b1},
    '{ROW_PIX, REG_FILL_COLOR,   32'h12345678, 8'd0,   1'b1, 32'h12345678, 1'b0},
    '{ROW_PIX, REG_FILL_COLOR,   32'h00000000, 8'd128, 1'b0, 32'h0,        1'b0},
    '{ROW_PIX, REG_FILL_COLOR,   32'hFFFFFFFF, 8'd128, 1'b0, 32'h0,        1'b0},
    '{ROW_PIX, REG_FILL_COLOR,   32'h80402010, 8'd1,   1'b0, 32'h0,        1'b0},
    '{ROW_CFG, REG_PIXEL_LAYOUT, 32'h00000001, 8'd0,   1'b0, 32'h0,        1'b0},
    '{ROW_PIX, REG_FILL_COLOR,   32'h00000000, 8'd255, 1'b1, 32'hFF112233, 1'b1},
    '{ROW_PIX, REG_FILL_COLOR,   32'h7F00FF80, 8'd200, 1'b0, 32'h0,        1'b0},
    '{ROW_CFG, REG_PIXEL_LAYOUT, 32'hFFFFFFFE, 8'd0,   1'b0, 32'h0,        1'b0},
    '{ROW_PIX, REG_FILL_COLOR,   32'hFFFFFFFF, 8'd255, 1'b1, 32'h332211FF, 1'b1},
    '{ROW_PIX, REG_FILL_COLOR,   32'h0000FF00, 8'd77,  1'b0, 32'h0,        1'b0},
    '{ROW_CFG, REG_PIXEL_LAYOUT, 32'h00000003, 8'd0,   1'b0, 32'h0,        1'b0},
    '{ROW_PIX, REG_FILL_COLOR,   32'h00000000, 8'd255, 1'b1, 32'h112233FF, 1'b1},
    '{ROW_PIX, REG_FILL_COLOR,   32'hFF0000FF, 8'd254, 1'b0, 32'h0,        1'b0},
    '{ROW_CFG, REG_FILL_COLOR,   32'hFFFFFF01, 8'd0,   1'b0, 32'h0,        1'b0},
    '{ROW_PIX, REG_FILL_COLOR,   32'h5A5A5A5A, 8'd255, 1'b0, 32'h0,        1'b0},
    '{ROW_PIX, REG_FILL_COLOR,   32'h5A5A5A5A, 8'd254, 1'b1, 32'h5A5A5A5A, 1'b0},
    '{ROW_CFG, REG_FILL_COLOR,   32'hFFFFFFFE, 8'd0,   1'b0, 32'h0,        1'b0},
    '{ROW_PIX, REG_FILL_COLOR,   32'h00000000, 8'd255, 1'b0, 32'h0,        1'b0},
    '{ROW_PIX, REG_FILL_COLOR,   32'hFE000000, 8'd255, 1'b0, 32'h0,        1'b0},
    '{ROW_CFG, REG_FILL_COLOR,   32'hFFFFFFFF, 8'd0,   1'b0, 32'h0,        1'b0},
    '{ROW_CFG, REG_PIXEL_LAYOUT, 32'h00000000, 8'd0,   1'b0, 32'h0,        1'b0},
    '{ROW_PIX, REG_FILL_COLOR,   32'hFFFFFFFF, 8'd128, 1'b0, 32'h0,        1'b0},
    '{ROW_PIX, REG_FILL_COLOR,   32'h00FFFFFF, 8'd1,   1'b0, 32'h0,        1'b0},
    '{ROW_PIX, REG_FILL_COLOR,   32'h80808080, 8'd255, 1'b1, 32'hFFFFFFFF, 1'b1},
    '{ROW_PIX, REG_FILL_COLOR,   32'hFEFFFFFF, 8'd200, 1'b0, 32'h0,        1'b0}
  };

  localparam int RAND_SEGMENTS = 13;
  localparam int SEG_PIXELS    = 50;

  logic             clk;
  logic             rst;
  logic             start;
  logic             busy;
  logic [PIX_W-1:0] dest_pixel;
  logic [CH_W-1:0]  coverage;
  logic             done;
  logic [PIX_W-1:0] new_pixel;
  logic             changed;
  logic             cfg_valid;
  logic             cfg_ready;
  cfg_idx_t         cfg_index;
  logic [PIX_W-1:0] cfg_data;

  logic [PIX_W-1:0] fill_reg;
  layout_e          layout_reg;
  blend_res_t       pending_blends [$];
  blend_res_t       oldest;
  int               mismatches;

  coverage_alpha_blend DUT (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .dest_pixel (dest_pixel),
    .coverage   (coverage),
    .done       (done),
    .new_pixel  (new_pixel),
    .changed    (changed),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic int chan_pos(input layout_e lay, input chan_e ch);
    case (ch)
      CH_RED: begin
        case (lay)
          LAYOUT_RGBA: return 0;
          LAYOUT_BGRA: return 2;
          LAYOUT_ARGB: return 1;
          default:     return 3;
        endcase
      end
      CH_GREEN: begin
        return (lay == LAYOUT_RGBA || lay == LAYOUT_BGRA) ? 1 : 2;
      end
      CH_BLUE: begin
        case (lay)
          LAYOUT_RGBA: return 2;
          LAYOUT_BGRA: return 0;
          LAYOUT_ARGB: return 3;
          default:     return 1;
        endcase
      end
      default: begin
        return (lay == LAYOUT_RGBA || lay == LAYOUT_BGRA) ? 3 : 0;
      end
    endcase
  endfunction

  function automatic blend_res_t blend_pixel(input logic [PIX_W-1:0] px,
                                             input logic [CH_W-1:0] cov);
    int unsigned src_a;
    int unsigned dst_a;
    int unsigned out_a;
    int unsigned src_c;
    int unsigned dst_c;
    int unsigned mixed;
    int          pos;
    blend_res_t  r;
    src_a = (int'(fill_reg[7:0]) * int'(cov)) / 255;
    r.pixel = px;
    r.written = 1'b1;
    if (src_a == 0) begin
      r.written = 1'b0;
    end else if (src_a == ALPHA_FULL) begin
      for (int c = 0; c < 3; c++) begin
        pos = chan_pos(layout_reg, chan_e'(c));
        r.pixel[8*pos +: 8] = fill_reg[31-8*c -: 8];
      end
      r.pixel[8*chan_pos(layout_reg, CH_ALPHA) +: 8] = CH_MAX;
    end else begin
      dst_a = px[8*chan_pos(layout_reg, CH_ALPHA) +: 8];
      out_a = src_a + (dst_a * (255 - src_a)) / 255;
      if (out_a == 0) begin
        r.pixel = '0;
      end else begin
        for (int c = 0; c < 3; c++) begin
          pos = chan_pos(layout_reg, chan_e'(c));
          src_c = fill_reg[31-8*c -: 8];
          dst_c = px[8*pos +: 8];
          mixed = (src_c * src_a + (dst_c * dst_a * (255 - src_a)) / 255) / out_a;
          r.pixel[8*pos +: 8] = mixed[7:0];
        end
        r.pixel[8*chan_pos(layout_reg, CH_ALPHA) +: 8] = out_a[7:0];
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [PIX_W-1:0] got,
                                 input logic [PIX_W-1:0] want);
    $display("%0t: %s mismatch: got %h, expected %h", $realtime, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_blends.size() == 0) begin
        report_mismatch("unexpected result beat, new_pixel", new_pixel, '0);
      end else begin
        oldest = pending_blends.pop_front();
        if (new_pixel !== oldest.pixel) begin
          report_mismatch("new_pixel", new_pixel, oldest.pixel);
        end
        if (changed !== oldest.written) begin
          report_mismatch("changed", PIX_W'(changed), PIX_W'(oldest.written));
        end
      end
    end
  end

  // After a negedge; may idle first; returns after the negedge past acceptance with start high.
  task automatic send_pixel(input logic [PIX_W-1:0] px, input logic [CH_W-1:0] cov,
                            input int idle_pct, input logic typed,
                            input blend_res_t typed_res);
    while ($urandom_range(99) < idle_pct) begin
      start = 1'b0;
      @(negedge clk);
    end
    start = 1'b1;
    dest_pixel = px;
    coverage = cov;
    do @(posedge clk); while (busy);
    pending_blends.push_back(typed ? typed_res : blend_pixel(px, cov));
    @(negedge clk);
  endtask

  task automatic drain_results();
    start = 1'b0;
    while (pending_blends.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [PIX_W-1:0] value);
    drain_results();
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_FILL_COLOR) begin
      fill_reg = value;
    end else begin
      layout_reg = layout_e'(value[1:0]);
    end
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic logic [PIX_W-1:0] pick_fill();
    logic [PIX_W-1:0] f;
    f = $urandom;
    case ($urandom_range(5))
      0: f[7:0] = 8'd0;
      1: f[7:0] = 8'd255;
      2: f[7:0] = 8'd1;
      3: f[7:0] = 8'd254;
      default: ;
    endcase
    if ($urandom_range(7) == 0) f[31:8] = $urandom_range(1) ? 24'hFFFFFF : 24'h0;
    return f;
  endfunction

  function automatic logic [CH_W-1:0] pick_coverage();
    case ($urandom_range(9))
      0: return 8'd0;
      1: return 8'd255;
      2: return 8'd1;
      3: return 8'd254;
      default: return CH_W'($urandom_range(255));
    endcase
  endfunction

  function automatic logic [PIX_W-1:0] pick_dest();
    case ($urandom_range(11))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    blend_res_t typed_res;
    int         idle_pct;
    mismatches = 0;
    fill_reg = '0;
    layout_reg = LAYOUT_RGBA;
    rst = 1'b1;
    start = 1'b0;
    dest_pixel = '0;
    coverage = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_FILL_COLOR;
    cfg_data = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (DIR_ROWS[i]) begin
      if (DIR_ROWS[i].kind == ROW_CFG) begin
        write_reg(DIR_ROWS[i].idx, DIR_ROWS[i].data);
      end else begin
        typed_res.pixel = DIR_ROWS[i].want_pixel;
        typed_res.written = DIR_ROWS[i].want_written;
        send_pixel(DIR_ROWS[i].data, DIR_ROWS[i].cov, 9, DIR_ROWS[i].typed, typed_res);
      end
    end

    typed_res = '0;
    for (int seg = 0; seg < RAND_SEGMENTS; seg++) begin
      idle_pct = (seg < 5) ? 9 : (seg < 9) ? 73 : 0;
      if ($urandom_range(1)) begin
        write_reg(REG_FILL_COLOR, pick_fill());
        write_reg(REG_PIXEL_LAYOUT, $urandom);
      end else begin
        write_reg(REG_PIXEL_LAYOUT, $urandom);
        write_reg(REG_FILL_COLOR, pick_fill());
      end
      for (int n = 0; n < SEG_PIXELS; n++) begin
        send_pixel(pick_dest(), pick_coverage(), idle_pct, 1'b0, typed_res);
      end
    end

    drain_results();
    repeat (20) @(negedge clk);
    if (mismatches == 0 && pending_blends.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/cab_pkg.sv
sv/cab_div.sv
sv/coverage_alpha_blend.sv
dv/tb.sv
